@@ rtl/three_body_rotating_frame_accel_defines.svh @@
// Assertion macros for the three-body acceleration block.
`ifndef THREE_BODY_ROTATING_FRAME_ACCEL_DEFINES_SVH
`define THREE_BODY_ROTATING_FRAME_ACCEL_DEFINES_SVH
`ifndef SYNTH
`define TBR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbr check failed");
`define TBR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbr check failed");
`else
`define TBR_ASSERT_IMP(name, ante, cons)
`define TBR_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ rtl/tbr_pkg.sv @@
// Shared widths, codes and types of the three-body acceleration block.
package tbr_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;

  localparam int MAGW     = WORD_BITS + 1;          // |x - xk|
  localparam int SW       = 2 * MAGW + 2;           // sum of three squares
  localparam int RW       = SW / 2;                 // floor sqrt
  localparam int DENW     = SW + RW;                // S * R
  localparam int NUMW     = 2 * WORD_BITS + 2 * FRAC_BITS;
  localparam int GRAV_LAT = RW + 2 + NUMW;
  localparam int CORW     = 2 * WORD_BITS + FRAC_BITS;
  localparam int CENW     = 3 * WORD_BITS - 2;
  localparam int PREW     = ((CORW > CENW) ? CORW : CENW) + 2;
  localparam int ROTW     = PREW - 2 * FRAC_BITS;
  localparam int ACCW     = ((NUMW > ROTW) ? NUMW : ROTW) + 3;

  localparam int IN_TDATA_W  = ((5 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * WORD_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MU_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MU_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_X  = 3'd4;

  typedef struct packed {
    logic signed [ROTW-1:0] rot_x;
    logic signed [ROTW-1:0] rot_y;
    logic                   neg_dx0;
    logic                   neg_dx1;
    logic                   neg_y;
    logic                   sing;
  } tbr_ctx_t;
endpackage

@@ rtl/three_body_rotating_frame_accel.sv @@
// Top level: rotating-frame acceleration of the light body, fully pipelined.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: pos_x, pos_y, pos_z, vel_x, vel_y
// m_*      out  m_tvalid/m_tready  m_tdata: acc_x, acc_y; m_tuser: singular, saturated
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// One item per cycle while the output stage does not stall the pipe; the depth is
// set by the 112-step restoring dividers and the 34-step square root in tbr_grav.
// rst clears valid bits, the output stage and the registers to reset values.
// The whole pipe moves on one enable; a two-entry output stage lets input
// transfers continue while one result waits, and stalls the pipe only when
// both entries are full and a result sits in the last stage.
`include "three_body_rotating_frame_accel_defines.svh"
module three_body_rotating_frame_accel import tbr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y (lowest first)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // acc_x, acc_y (lowest first)
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // singular, saturated (lowest first)
  output logic [1:0]             m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WORD_BITS-1:0]   cfg_data
);
  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int USR_SING = 0;
  localparam int USR_SAT  = 1;
  localparam logic [W-1:0] ACC_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ACC_MIN = {1'b1, {(W-1){1'b0}}};

  // configuration registers
  logic [W-2:0] omega, mu_first, mu_second;
  logic [W-1:0] first_x, second_x;
  logic [2*W-3:0] wsq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega     <= (W-1)'(1) << F;
      mu_first  <= '0;
      mu_second <= '0;
      first_x   <= '0;
      second_x  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OMEGA:     omega     <= cfg_data[W-2:0];
        REG_MU_FIRST:  mu_first  <= cfg_data[W-2:0];
        REG_MU_SECOND: mu_second <= cfg_data[W-2:0];
        REG_FIRST_X:   first_x   <= cfg_data;
        REG_SECOND_X:  second_x  <= cfg_data;
        default: ;
      endcase
    end
  end

  // omega^2 follows the register; read in P3
  always_ff @(posedge clk) wsq <= omega * omega;

  // pipe enable and output stage
  logic run;
  logic vb;
  logic o_valid, k_valid;
  logic [OUT_TDATA_W-1:0] o_data, k_data, b_data;
  logic [1:0] o_user, k_user, b_user;

  assign run      = !vb || !k_valid;
  assign s_tready = run;

  // P1: input register
  logic v1;
  logic signed [W-1:0] p1_x, p1_y, p1_z, p1_vx, p1_vy;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (run) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (run) begin
      p1_x  <= s_tdata[0*W +: W];
      p1_y  <= s_tdata[1*W +: W];
      p1_z  <= s_tdata[2*W +: W];
      p1_vx <= s_tdata[3*W +: W];
      p1_vy <= s_tdata[4*W +: W];
    end
  end

  // P2: offsets to the primaries, magnitudes and signs
  logic v2;
  logic [MAGW-1:0] m_dx0, m_dx1;
  logic [W-1:0] m_x, m_y, m_z, m_vx, m_vy;
  logic n2_dx0, n2_dx1, n2_x, n2_y, n2_vx, n2_vy;
  logic signed [W:0] dx0, dx1;
  always_comb begin
    dx0 = {p1_x[W-1], p1_x} - {first_x[W-1], first_x};
    dx1 = {p1_x[W-1], p1_x} - {second_x[W-1], second_x};
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (run) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (run) begin
      n2_dx0 <= dx0[W];
      n2_dx1 <= dx1[W];
      n2_x   <= p1_x[W-1];
      n2_y   <= p1_y[W-1];
      n2_vx  <= p1_vx[W-1];
      n2_vy  <= p1_vy[W-1];
      m_dx0  <= dx0[W] ? MAGW'(-dx0) : MAGW'(dx0);
      m_dx1  <= dx1[W] ? MAGW'(-dx1) : MAGW'(dx1);
      m_x    <= p1_x[W-1]  ? W'(-p1_x)  : W'(p1_x);
      m_y    <= p1_y[W-1]  ? W'(-p1_y)  : W'(p1_y);
      m_z    <= p1_z[W-1]  ? W'(-p1_z)  : W'(p1_z);
      m_vx   <= p1_vx[W-1] ? W'(-p1_vx) : W'(p1_vx);
      m_vy   <= p1_vy[W-1] ? W'(-p1_vy) : W'(p1_vy);
    end
  end

  // P3: all products
  logic v3;
  logic [2*MAGW-1:0] sq_dx0, sq_dx1;
  logic [2*W-1:0] sq_y, sq_z;
  logic [2*W-1:0] pn_x0, pn_x1;
  logic [2*W-2:0] pn_y0, pn_y1;
  logic [2*W-2:0] wv_x, wv_y;        // omega*|vel_y|, omega*|vel_x|
  logic [2*W-2:0] cl_x, ch_x, cl_y, ch_y;
  logic n3_dx0, n3_dx1, n3_x, n3_y, n3_vx, n3_vy, s3_sing;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (run) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (run) begin
      sq_dx0  <= m_dx0 * m_dx0;
      sq_dx1  <= m_dx1 * m_dx1;
      sq_y    <= m_y * m_y;
      sq_z    <= m_z * m_z;
      pn_x0   <= mu_first * m_dx0;
      pn_x1   <= mu_second * m_dx1;
      pn_y0   <= mu_first * m_y;
      pn_y1   <= mu_second * m_y;
      wv_x    <= omega * m_vy;
      wv_y    <= omega * m_vx;
      cl_x    <= wsq[W-2:0] * m_x;
      ch_x    <= wsq[2*W-3:W-1] * m_x;
      cl_y    <= wsq[W-2:0] * m_y;
      ch_y    <= wsq[2*W-3:W-1] * m_y;
      n3_dx0  <= n2_dx0;
      n3_dx1  <= n2_dx1;
      n3_x    <= n2_x;
      n3_y    <= n2_y;
      n3_vx   <= n2_vx;
      n3_vy   <= n2_vy;
      // on a primary: offset, y and z all zero
      s3_sing <= (m_y == '0) && (m_z == '0) && ((m_dx0 == '0) || (m_dx1 == '0));
    end
  end

  // P4: squared distances, numerators, signed rotation terms
  logic v4;
  logic [SW-1:0] s0, s1;
  logic [NUMW-1:0] nx0, ny0, nx1, ny1;
  logic signed [PREW-1:0] cor_x, cen_x, cor_y, cen_y;
  logic n4_dx0, n4_dx1, n4_y, s4_sing;
  logic [CORW-1:0] corm_x, corm_y;
  logic [CENW-1:0] cenm_x, cenm_y;
  always_comb begin
    corm_x = CORW'(wv_x) << (F + 1);
    corm_y = CORW'(wv_y) << (F + 1);
    cenm_x = CENW'(cl_x) + (CENW'(ch_x) << (W - 1));
    cenm_y = CENW'(cl_y) + (CENW'(ch_y) << (W - 1));
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (run) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (run) begin
      s0      <= SW'(sq_dx0) + SW'(sq_y) + SW'(sq_z);
      s1      <= SW'(sq_dx1) + SW'(sq_y) + SW'(sq_z);
      nx0     <= NUMW'(pn_x0) << (2 * F);
      nx1     <= NUMW'(pn_x1) << (2 * F);
      ny0     <= NUMW'(pn_y0) << (2 * F);
      ny1     <= NUMW'(pn_y1) << (2 * F);
      // Coriolis: +2w vy on x, -2w vx on y
      cor_x   <= n3_vy  ? -PREW'(corm_x) : PREW'(corm_x);
      cor_y   <= !n3_vx ? -PREW'(corm_y) : PREW'(corm_y);
      cen_x   <= n3_x   ? -PREW'(cenm_x) : PREW'(cenm_x);
      cen_y   <= n3_y   ? -PREW'(cenm_y) : PREW'(cenm_y);
      n4_dx0  <= n3_dx0;
      n4_dx1  <= n3_dx1;
      n4_y    <= n3_y;
      s4_sing <= s3_sing;
    end
  end

  // gravity magnitudes of both primaries, from the P4 sums and numerators
  logic [NUMW-1:0] g0x, g0y, g1x, g1y;
  tbr_grav u_grav0 (
    .clk(clk), .run(run), .s_in(s0), .num_x(nx0), .num_y(ny0),
    .quo_x(g0x), .quo_y(g0y)
  );
  tbr_grav u_grav1 (
    .clk(clk), .run(run), .s_in(s1), .num_x(nx1), .num_y(ny1),
    .quo_x(g1x), .quo_y(g1y)
  );

  // P5 onward: rotation floored to word scale, then held beside the dividers
  logic signed [PREW-1:0] rsum_x, rsum_y;
  always_comb begin
    rsum_x = cor_x + cen_x;
    rsum_y = cor_y + cen_y;
  end

  tbr_ctx_t cd [0:GRAV_LAT-1];
  logic     vd [0:GRAV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else if (run) vd[0] <= v4;
  end
  always_ff @(posedge clk) begin
    if (run) begin
      cd[0].rot_x   <= ROTW'(rsum_x >>> (2 * F));
      cd[0].rot_y   <= ROTW'(rsum_y >>> (2 * F));
      cd[0].neg_dx0 <= n4_dx0;
      cd[0].neg_dx1 <= n4_dx1;
      cd[0].neg_y   <= n4_y;
      cd[0].sing    <= s4_sing;
    end
  end

  for (genvar i = 1; i < GRAV_LAT; i++) begin : g_ctx
    always_ff @(posedge clk) begin
      if (rst) vd[i] <= 1'b0;
      else if (run) vd[i] <= vd[i-1];
    end
    always_ff @(posedge clk) begin
      if (run) cd[i] <= cd[i-1];
    end
  end

  // PA: full-width sums
  tbr_ctx_t ce;
  logic va, sa_sing;
  logic signed [ACCW-1:0] sx0, sx1, sy0, sy1;
  logic signed [ACCW-1:0] acc_x_w, acc_y_w;
  always_comb begin
    ce  = cd[GRAV_LAT-1];
    sx0 = ce.neg_dx0 ? -ACCW'({1'b0, g0x}) : ACCW'({1'b0, g0x});
    sx1 = ce.neg_dx1 ? -ACCW'({1'b0, g1x}) : ACCW'({1'b0, g1x});
    sy0 = ce.neg_y   ? -ACCW'({1'b0, g0y}) : ACCW'({1'b0, g0y});
    sy1 = ce.neg_y   ? -ACCW'({1'b0, g1y}) : ACCW'({1'b0, g1y});
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (run) va <= vd[GRAV_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (run) begin
      acc_x_w <= ACCW'(ce.rot_x) - sx0 - sx1;
      acc_y_w <= ACCW'(ce.rot_y) - sy0 - sy1;
      sa_sing <= ce.sing;
    end
  end

  // PB: clamp to the word, singular override
  logic in_x, in_y;
  logic [W-1:0] cx, cy;
  always_comb begin
    in_x = (acc_x_w[ACCW-1:W-1] == '0) || (acc_x_w[ACCW-1:W-1] == '1);
    in_y = (acc_y_w[ACCW-1:W-1] == '0) || (acc_y_w[ACCW-1:W-1] == '1);
    cx   = in_x ? acc_x_w[W-1:0] : (acc_x_w[ACCW-1] ? ACC_MIN : ACC_MAX);
    cy   = in_y ? acc_y_w[W-1:0] : (acc_y_w[ACCW-1] ? ACC_MIN : ACC_MAX);
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (run) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (run) begin
      b_data           <= sa_sing ? '0 : OUT_TDATA_W'({cy, cx});
      b_user[USR_SING] <= sa_sing;
      b_user[USR_SAT]  <= !sa_sing && (!in_x || !in_y);
    end
  end

  // two-entry output stage
  logic pop, push;
  assign pop  = o_valid && m_tready;
  assign push = vb && run;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (pop || !o_valid) begin
      if (k_valid) begin
        o_valid <= 1'b1;
        k_valid <= push;
      end else begin
        o_valid <= push;
      end
    end else if (push) begin
      k_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !o_valid) begin
      if (k_valid) begin
        o_data <= k_data;
        o_user <= k_user;
        k_data <= b_data;
        k_user <= b_user;
      end else begin
        o_data <= b_data;
        o_user <= b_user;
      end
    end else if (push) begin
      k_data <= b_data;
      k_user <= b_user;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;
  assign m_tuser  = o_user;

  `TBR_ASSERT_IMP(a_skid_needs_head, k_valid, o_valid)
  `TBR_ASSERT_IMP(a_full_stalls_input, k_valid && vb, !s_tready)
  `TBR_ASSERT_IMP(a_sing_zero, m_tvalid && m_tuser[USR_SING], (m_tdata == '0) && !m_tuser[USR_SAT])
  `TBR_ASSERT_IMP(a_sat_at_limit, m_tvalid && m_tuser[USR_SAT], (m_tdata[W-1:0] == ACC_MAX) || (m_tdata[W-1:0] == ACC_MIN) || (m_tdata[2*W-1:W] == ACC_MAX) || (m_tdata[2*W-1:W] == ACC_MIN))
  `TBR_ASSERT_NXT(a_skid_drains, o_valid && k_valid && m_tready, o_valid)
endmodule

@@ rtl/tbr_grav.sv @@
// Gravity magnitude pipeline of one primary: sqrt, S*R, two long divisions.
module tbr_grav import tbr_pkg::*; (
  input  logic            clk,
  input  logic            run,
  input  logic [SW-1:0]   s_in,
  input  logic [NUMW-1:0] num_x,
  input  logic [NUMW-1:0] num_y,
  output logic [NUMW-1:0] quo_x,
  output logic [NUMW-1:0] quo_y
);
  localparam int REMW = RW + 2;

  // square root, two bits of S per stage
  logic [SW-1:0]   sq_sr   [0:RW];
  logic [SW-1:0]   sq_keep [0:RW];
  logic [RW-1:0]   sq_root [0:RW];
  logic [REMW-1:0] sq_rem  [0:RW];
  logic [NUMW-1:0] sq_nx   [0:RW];
  logic [NUMW-1:0] sq_ny   [0:RW];

  assign sq_sr[0]   = s_in;
  assign sq_keep[0] = s_in;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_nx[0]   = num_x;
  assign sq_ny[0]   = num_y;

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    logic [REMW+1:0] t;
    logic [REMW+1:0] trial;
    always_comb begin
      t     = {sq_rem[j-1], sq_sr[j-1][SW-1:SW-2]};
      trial = (REMW+2)'({sq_root[j-1], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (run) begin
        sq_sr[j]   <= sq_sr[j-1] << 2;
        sq_keep[j] <= sq_keep[j-1];
        sq_nx[j]   <= sq_nx[j-1];
        sq_ny[j]   <= sq_ny[j-1];
        if (t >= trial) begin
          sq_rem[j]  <= REMW'(t - trial);
          sq_root[j] <= {sq_root[j-1][RW-2:0], 1'b1};
        end else begin
          sq_rem[j]  <= t[REMW-1:0];
          sq_root[j] <= {sq_root[j-1][RW-2:0], 1'b0};
        end
      end
    end
  end

  // S * R in two lanes, then the lane sum
  logic [2*RW-1:0] p_lo, p_hi;
  logic [NUMW-1:0] m1_nx, m1_ny;
  logic [DENW-1:0] den;
  logic [NUMW-1:0] m2_nx, m2_ny;

  always_ff @(posedge clk) begin
    if (run) begin
      p_lo  <= sq_keep[RW][RW-1:0] * sq_root[RW];
      p_hi  <= sq_keep[RW][SW-1:RW] * sq_root[RW];
      m1_nx <= sq_nx[RW];
      m1_ny <= sq_ny[RW];
      den   <= DENW'(p_lo) + (DENW'(p_hi) << RW);
      m2_nx <= m1_nx;
      m2_ny <= m1_ny;
    end
  end

  // restoring division, one quotient bit per stage; quotient shifts in
  // where the numerator shifts out
  logic [DENW-1:0] dv_den [0:NUMW];
  logic [DENW-1:0] dv_rx  [0:NUMW];
  logic [DENW-1:0] dv_ry  [0:NUMW];
  logic [NUMW-1:0] dv_qx  [0:NUMW];
  logic [NUMW-1:0] dv_qy  [0:NUMW];

  assign dv_den[0] = den;
  assign dv_rx[0]  = '0;
  assign dv_ry[0]  = '0;
  assign dv_qx[0]  = m2_nx;
  assign dv_qy[0]  = m2_ny;

  for (genvar i = 1; i <= NUMW; i++) begin : g_div
    logic [DENW:0] tx, ty, dd;
    logic          bx, by;
    always_comb begin
      tx = {dv_rx[i-1], dv_qx[i-1][NUMW-1]};
      ty = {dv_ry[i-1], dv_qy[i-1][NUMW-1]};
      dd = {1'b0, dv_den[i-1]};
      bx = (tx >= dd);
      by = (ty >= dd);
    end
    always_ff @(posedge clk) begin
      if (run) begin
        dv_den[i] <= dv_den[i-1];
        dv_rx[i]  <= bx ? DENW'(tx - dd) : tx[DENW-1:0];
        dv_ry[i]  <= by ? DENW'(ty - dd) : ty[DENW-1:0];
        dv_qx[i]  <= {dv_qx[i-1][NUMW-2:0], bx};
        dv_qy[i]  <= {dv_qy[i-1][NUMW-2:0], by};
      end
    end
  end

  assign quo_x = dv_qx[NUMW];
  assign quo_y = dv_qy[NUMW];
endmodule

@@ sim/tbr_accel_checker.sv @@
// Checker for the three-body acceleration block: predicts, queues and compares results.
`timescale 1ns / 1ps
module tbr_accel_checker import tbr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [1:0]             m_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WORD_BITS-1:0]   cfg_data,
  output int                     fail_count,
  output int                     waiting,
  output int                     results_seen
);

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic        singular;
    logic        saturated;
  } accel_t;

  accel_t accel_q[$];

  logic [30:0]        omega_r, mu0_r, mu1_r;
  logic signed [31:0] px0_r, px1_r;

  function automatic big_t root_floor(big_t s);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [255:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {192'd0, c} * {192'd0, c};
      if (sq <= s) r = c;
    end
    return $signed({192'd0, r});
  endfunction

  function automatic logic [31:0] clamp_word(big_t t, inout logic sat);
    big_t hi_lim;
    big_t lo_lim;
    hi_lim = 256'sd2147483647;
    lo_lim = -256'sd2147483648;
    if (t > hi_lim) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (t < lo_lim) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return t[31:0];
  endfunction

  function automatic accel_t predict_accel(logic [IN_TDATA_W-1:0] d);
    big_t   x, y, z, vx, vy, om, m0, m1, dx0, dx1, s0, s1, den0, den1, ax, ay, yz;
    logic   sat;
    accel_t r;
    x   = $signed(d[31:0]);
    y   = $signed(d[63:32]);
    z   = $signed(d[95:64]);
    vx  = $signed(d[127:96]);
    vy  = $signed(d[159:128]);
    om  = $signed({225'd0, omega_r});
    m0  = $signed({225'd0, mu0_r});
    m1  = $signed({225'd0, mu1_r});
    dx0 = x - big_t'(px0_r);
    dx1 = x - big_t'(px1_r);
    yz  = y * y + z * z;
    s0  = dx0 * dx0 + yz;
    s1  = dx1 * dx1 + yz;
    r   = '0;
    if (s0 == 0 || s1 == 0) begin
      r.singular = 1'b1;
      return r;
    end
    den0 = s0 * root_floor(s0);
    den1 = s1 * root_floor(s1);
    // rotation part at scale 2^-48, floored; gravity truncated toward zero
    ax = ((((om * vy) <<< 25) + om * om * x) >>> 48)
         - ((m0 * dx0) <<< 48) / den0 - ((m1 * dx1) <<< 48) / den1;
    ay = ((-((om * vx) <<< 25) + om * om * y) >>> 48)
         - ((m0 * y) <<< 48) / den0 - ((m1 * y) <<< 48) / den1;
    sat = 1'b0;
    r.acc_x = clamp_word(ax, sat);
    r.acc_y = clamp_word(ay, sat);
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    accel_t exp_r;
    accel_t got_r;
    if (rst) begin
      omega_r = 31'(1 << FRAC_BITS);
      mu0_r = '0;
      mu1_r = '0;
      px0_r = '0;
      px1_r = '0;
      accel_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OMEGA:     omega_r = cfg_data[30:0];
          REG_MU_FIRST:  mu0_r = cfg_data[30:0];
          REG_MU_SECOND: mu1_r = cfg_data[30:0];
          REG_FIRST_X:   px0_r = cfg_data;
          REG_SECOND_X:  px1_r = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got_r = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]};
        results_seen <= results_seen + 1;
        if (accel_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result transfer: %h", got_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = accel_q.pop_front();
          if (got_r.acc_x != exp_r.acc_x || got_r.acc_y != exp_r.acc_y ||
              got_r.singular != exp_r.singular || got_r.saturated != exp_r.saturated) begin
            if (fail_count < 10)
              $display("mismatch: acc_x %h/%h acc_y %h/%h sing %b/%b sat %b/%b (exp/got)",
                       exp_r.acc_x, got_r.acc_x, exp_r.acc_y, got_r.acc_y,
                       exp_r.singular, got_r.singular, exp_r.saturated, got_r.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) accel_q.push_back(predict_accel(s_tdata));
    end
    waiting <= accel_q.size();
  end

endmodule

@@ sim/tb_three_body_rotating_frame_accel.sv @@
// Testbench top for the three-body acceleration block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_three_body_rotating_frame_accel;
  import tbr_pkg::*;

  localparam int LIMIT      = 400000;  // cycles
  localparam int N_PHASES   = 6;
  localparam int PER_PHASE  = 163;
  localparam int DRAIN_WAIT = 200;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // pos_x, pos_y, pos_z, vel_x, vel_y (lowest first)
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // acc_x, acc_y (lowest first)
  logic [OUT_TDATA_W-1:0] m_tdata;
  // singular, saturated (lowest first)
  logic [1:0]             m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [WORD_BITS-1:0]   cfg_data = '0;

  int   fail_count, waiting, results_seen;
  int   cycles = 0;
  int   items_sent = 0;
  logic calm = 1'b0;  // no idling on either side while set

  // tb copies of the primary positions, used to aim items near them
  logic signed [31:0] prim0 = '0, prim1 = '0;

  three_body_rotating_frame_accel u_top (.*);

  tbr_accel_checker u_chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random backpressure
  always @(posedge clk)
    m_tready <= calm || ($urandom_range(99) >= 17);

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] vx, logic [31:0] vy);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {vy, vx, pz, py, px};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (!calm && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_source();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with the pipe empty
  task automatic drain();
    idle_source();
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_frame(logic [31:0] om, logic [31:0] m0, logic [31:0] m1,
                            logic [31:0] x0, logic [31:0] x1);
    drain();
    write_reg(REG_OMEGA, om);
    write_reg(REG_MU_FIRST, m0);
    write_reg(REG_MU_SECOND, m1);
    write_reg(REG_FIRST_X, x0);
    write_reg(REG_SECOND_X, x1);
    prim0 = x0;
    prim1 = x1;
  endtask

  function automatic logic [31:0] jitter();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(2, 31);
  endfunction

  task automatic send_random();
    int                 mode;
    logic signed [31:0] base;
    mode = $urandom_range(99);
    base = $urandom_range(1) ? prim0 : prim1;
    if (mode < 45) begin
      // near a primary: the interesting gravity region
      send_point(base + jitter(), jitter(), jitter(), jitter(), jitter());
    end else if (mode < 50) begin
      // right on a primary
      send_point(base, 32'd0, 32'd0, $urandom, $urandom);
    end else if (mode < 55) begin
      // one step off a primary: huge pull, saturates
      send_point(base + ($urandom_range(1) ? 32'sd1 : -32'sd1), 32'd0,
                 $urandom_range(1), $urandom, $urandom);
    end else begin
      send_point($urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset frame: omega 1.0, no mass, both primaries at origin
    send_point(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);          // singular
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0100_0000, 32'd0, 32'd0, 32'd0, 32'd0);
    send_point(32'd0, 32'd0, 32'h0100_0000, 32'd0, 32'd0);   // z only
    send_point(32'd1, 32'hffff_ffff, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'hff00_0000, 32'h0100_0000, 32'd0, 32'h0100_0000, 32'hff00_0000);

    // earth-moon-like system
    load_frame(32'h0100_0000, 32'd16572437, 32'd204779, -32'sd204779, 32'd16572437);
    write_reg(3'd5, $urandom);                                 // unused index
    write_reg(3'd7, $urandom);
    send_point(-32'sd204779, 32'd0, 32'd0, 32'd0, 32'd0);      // on first primary
    send_point(32'd16572437, 32'd0, 32'd0, 32'd0, 32'd0);      // on second
    send_point(32'd16572438, 32'd0, 32'd0, 32'd0, 32'd0);      // one step off
    send_point(32'd0, 32'h0100_0000, 32'd0, 32'h0080_0000, 32'hff80_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0);
    repeat (PER_PHASE) send_random();

    for (int ph = 0; ph < N_PHASES - 1; ph++) begin
      case (ph)
        0: load_frame(32'h7fff_ffff, 32'h7fff_ffff, 32'd0,
                      32'h8000_0000, 32'h7fff_ffff);
        1: load_frame(32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'd0);
        2: load_frame($urandom, $urandom, $urandom, $urandom, $urandom);
        3: load_frame(32'h0001_0000, 32'd1, 32'h0200_0000,
                      32'hfe00_0000, 32'h0300_0000);
        default: load_frame($urandom, $urandom_range(1 << 26), $urandom_range(1 << 26),
                            jitter(), jitter());
      endcase
      calm = (ph == 2);  // one phase with no idling at all
      repeat (PER_PHASE - 40 * (ph == 4)) send_random();
    end
    calm = 1'b0;

    idle_source();
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d points over %0d register settings, %0d results checked",
             items_sent, N_PHASES + 1, results_seen);
    $display("includes singular, saturating, extreme and unused-index cases");
    if (fail_count == 0 && waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tbr_pkg.sv
rtl/tbr_grav.sv
rtl/three_body_rotating_frame_accel.sv
sim/tbr_accel_checker.sv
sim/tb_three_body_rotating_frame_accel.sv
